// ===== rtl/glob_pattern_tokenizer_defines.svh =====
// assertion macros for the glob pattern tokenizer
// used by glob_pattern_tokenizer.sv, no other dependencies
`ifndef GLOB_PATTERN_TOKENIZER_DEFINES_SVH
`define GLOB_PATTERN_TOKENIZER_DEFINES_SVH
`ifndef SYNTHESIS
`define GPT_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("glob tokenizer check failed");
`define GPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("glob tokenizer sequence check failed");
`else
`define GPT_ASSERT(label, clk, rst, ante, cons)
`define GPT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/gpt_pkg.sv =====
// shared types and constants for the glob pattern tokenizer
// no dependencies
package gpt_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_OPEN     = 8'h5B;
  localparam logic [7:0] CH_BANG     = 8'h21;
  localparam logic [7:0] CH_DASH     = 8'h2D;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_CLOSE    = 8'h5D;

  typedef enum logic [2:0] {
    KIND_LITERAL   = 3'd0,
    KIND_CLASS     = 3'd1,
    KIND_NEG_CLASS = 3'd2,
    KIND_WILDCARD  = 3'd3,
    KIND_GLOB      = 3'd4,
    KIND_STATUS    = 3'd5
  } atom_kind_t;

  typedef enum logic [2:0] {
    MODE_TOP        = 3'd0,
    MODE_TOP_ESC    = 3'd1,
    MODE_CLS_START  = 3'd2,
    MODE_CLS_MEMBER = 3'd3,
    MODE_CLS_ESC    = 3'd4,
    MODE_CLS_AFTER  = 3'd5,
    MODE_RNG_NEED   = 3'd6,
    MODE_RNG_ESC    = 3'd7
  } mode_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_name;
  } in_req_t;

  typedef struct packed {
    atom_kind_t  atom_kind;
    logic [7:0]  literal_byte;
    logic [63:0] set_word;
    logic [1:0]  word_index;
    logic        last_of_run;
    logic        name_done;
    logic        name_valid;
    logic        name_is_pattern;
  } out_req_t;

  typedef struct packed {
    atom_kind_t       kind;
    logic [7:0]       lit;
    logic [3:0][63:0] set_words;
    logic             done;
    logic             name_valid;
    logic             name_pattern;
  } entry_t;

endpackage

// ===== rtl/glob_pattern_tokenizer.sv =====
// Glob pattern tokenizer: takes one name byte per cycle and turns it into literal, wildcard,
// glob and bracket-class atoms. Each byte is parsed in the cycle it is accepted; its first
// result goes into the atom queue and is then registered onto the atom channel. Every byte
// except a closing bracket gives at most one result, so the sustained rate is one byte per
// cycle. A class-closing bracket gives four results (the 256-bit member set as four 64-bit
// words), which the back end sends one word at a time from its word counter; the
// QUEUE_DEPTH-entry atom queue absorbs this; the byte channel stalls only on a full queue:
// when atom_stall holds the output, or when results outnumber bytes for longer than the
// queue covers, as with back-to-back short classes such as [a] (three bytes, four results).
// depends on gpt_pkg, gpt_front, gpt_queue, gpt_back and glob_pattern_tokenizer_defines.svh
`include "glob_pattern_tokenizer_defines.svh"

module glob_pattern_tokenizer #(
  parameter int QUEUE_DEPTH = gpt_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_stall,
  input  gpt_pkg::in_req_t  byte_req,
  output logic              atom_valid,
  input  logic              atom_stall,
  output gpt_pkg::out_req_t atom_req
);

  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            head_valid;
  gpt_pkg::entry_t push_entry;
  gpt_pkg::entry_t head_entry;
  logic            cls_word;
  logic            cls_last;
  logic            cls_step;
  logic [1:0]      out_idx;

  gpt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_req   (byte_req),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (push_entry)
  );

  gpt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  gpt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (q_pop),
    .atom_valid (atom_valid),
    .atom_stall (atom_stall),
    .atom_req   (atom_req)
  );

  assign cls_word = atom_valid && (atom_req.atom_kind == gpt_pkg::KIND_CLASS ||
                                   atom_req.atom_kind == gpt_pkg::KIND_NEG_CLASS);
  assign out_idx  = atom_req.word_index;
  assign cls_last = (out_idx == 2'd3);
  assign cls_step = cls_word && !atom_stall && !cls_last;

  `GPT_ASSERT(a_no_overflow, clk, rst, q_push, !q_full)
  `GPT_ASSERT(a_pop_has_head, clk, rst, q_pop, head_valid)
  `GPT_ASSERT(a_class_last_word, clk, rst, cls_word, atom_req.last_of_run == cls_last)
  `GPT_ASSERT_NEXT(a_word_order, clk, rst, cls_step, cls_word && out_idx == $past(out_idx) + 2'd1)

endmodule

// ===== rtl/gpt_front.sv =====
// front end: accepts name bytes, runs the parse state and builds at most one queue entry per accepted byte
// depends on gpt_pkg
module gpt_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            byte_valid,
  output logic            byte_stall,
  input  gpt_pkg::in_req_t byte_req,
  input  logic            q_full,
  output logic            q_push,
  output gpt_pkg::entry_t q_entry
);

  gpt_pkg::mode_t mode, mode_next;
  logic [255:0]   class_set, class_set_next;
  logic [7:0]     pending_first, pending_first_next;
  logic           class_negated, class_negated_next;
  logic           valid_flag, valid_flag_next;
  logic           pattern_flag, pattern_flag_next;

  logic           accept;
  logic [7:0]     c;
  logic           add_en;
  logic [7:0]     hi;
  logic [255:0]   range_mask;
  logic [255:0]   set_added;
  logic           do_member;
  logic           do_range;
  logic           emit;

  assign byte_stall = q_full;
  assign accept     = byte_valid && !q_full;
  assign c          = byte_req.char_in;
  assign q_push     = accept && emit;

  // inclusive range mask, shared by single members and ranges
  always_comb begin
    add_en = valid_flag &&
             ((mode == gpt_pkg::MODE_CLS_AFTER && c != gpt_pkg::CH_DASH) ||
              (mode == gpt_pkg::MODE_RNG_NEED && c != gpt_pkg::CH_BSLASH) ||
              (mode == gpt_pkg::MODE_RNG_ESC));
    hi = (mode == gpt_pkg::MODE_CLS_AFTER) ? pending_first : c;
    range_mask = ({256{1'b1}} << pending_first) & ({256{1'b1}} >> (8'd255 - hi));
    set_added = add_en ? (class_set | range_mask) : class_set;
  end

  always_comb begin
    mode_next          = mode;
    class_set_next     = class_set;
    pending_first_next = pending_first;
    class_negated_next = class_negated;
    valid_flag_next    = valid_flag;
    pattern_flag_next  = pattern_flag;
    do_member          = 1'b0;
    do_range           = 1'b0;
    emit               = 1'b0;
    q_entry            = '0;
    q_entry.kind       = gpt_pkg::KIND_STATUS;

    if (valid_flag) begin
      unique case (mode)
        gpt_pkg::MODE_TOP: begin
          if (c == gpt_pkg::CH_QUESTION) begin
            pattern_flag_next = 1'b1;
            emit              = 1'b1;
            q_entry.kind      = gpt_pkg::KIND_WILDCARD;
          end else if (c == gpt_pkg::CH_STAR) begin
            pattern_flag_next = 1'b1;
            emit              = 1'b1;
            q_entry.kind      = gpt_pkg::KIND_GLOB;
          end else if (c == gpt_pkg::CH_OPEN) begin
            pattern_flag_next  = 1'b1;
            class_set_next     = '0;
            class_negated_next = 1'b0;
            mode_next          = gpt_pkg::MODE_CLS_START;
          end else if (c == gpt_pkg::CH_BSLASH) begin
            mode_next = gpt_pkg::MODE_TOP_ESC;
          end else begin
            emit         = 1'b1;
            q_entry.kind = gpt_pkg::KIND_LITERAL;
            q_entry.lit  = c;
          end
        end
        gpt_pkg::MODE_TOP_ESC: begin
          emit         = 1'b1;
          q_entry.kind = gpt_pkg::KIND_LITERAL;
          q_entry.lit  = c;
          mode_next    = gpt_pkg::MODE_TOP;
        end
        gpt_pkg::MODE_CLS_START: begin
          if (c == gpt_pkg::CH_BANG) begin
            class_negated_next = 1'b1;
            mode_next          = gpt_pkg::MODE_CLS_MEMBER;
          end else begin
            do_member = 1'b1;
          end
        end
        gpt_pkg::MODE_CLS_MEMBER: begin
          do_member = 1'b1;
        end
        gpt_pkg::MODE_CLS_ESC: begin
          pending_first_next = c;
          mode_next          = gpt_pkg::MODE_CLS_AFTER;
        end
        gpt_pkg::MODE_CLS_AFTER: begin
          if (c == gpt_pkg::CH_DASH) begin
            mode_next = gpt_pkg::MODE_RNG_NEED;
          end else begin
            do_member = 1'b1;
          end
        end
        gpt_pkg::MODE_RNG_NEED: begin
          if (c == gpt_pkg::CH_BSLASH) begin
            mode_next = gpt_pkg::MODE_RNG_ESC;
          end else begin
            do_range = 1'b1;
          end
        end
        gpt_pkg::MODE_RNG_ESC: begin
          do_range = 1'b1;
        end
      endcase
    end

    if (do_range) begin
      if (pending_first > c) begin
        valid_flag_next = 1'b0;
        class_set_next  = '0;
        mode_next       = gpt_pkg::MODE_TOP;
      end else begin
        class_set_next = set_added;
        mode_next      = gpt_pkg::MODE_CLS_MEMBER;
      end
    end

    // a close bracket ends the class only once a member is in the set
    if (do_member) begin
      if (c == gpt_pkg::CH_CLOSE && set_added != '0) begin
        emit               = 1'b1;
        q_entry.kind       = class_negated ? gpt_pkg::KIND_NEG_CLASS : gpt_pkg::KIND_CLASS;
        q_entry.set_words  = set_added;
        class_set_next     = '0;
        class_negated_next = 1'b0;
        mode_next          = gpt_pkg::MODE_TOP;
      end else if (c == gpt_pkg::CH_BSLASH) begin
        class_set_next = set_added;
        mode_next      = gpt_pkg::MODE_CLS_ESC;
      end else begin
        class_set_next     = set_added;
        pending_first_next = c;
        mode_next          = gpt_pkg::MODE_CLS_AFTER;
      end
    end

    if (byte_req.end_of_name) begin
      if (valid_flag_next && mode_next != gpt_pkg::MODE_TOP) begin
        valid_flag_next = 1'b0;
      end
      if (!emit) begin
        emit         = 1'b1;
        q_entry.kind = gpt_pkg::KIND_STATUS;
      end
    end

    q_entry.done         = byte_req.end_of_name;
    q_entry.name_valid   = valid_flag_next;
    q_entry.name_pattern = pattern_flag_next;

    // per-name state returns to reset after the last byte
    if (byte_req.end_of_name) begin
      mode_next          = gpt_pkg::MODE_TOP;
      class_set_next     = '0;
      pending_first_next = '0;
      class_negated_next = 1'b0;
      valid_flag_next    = 1'b1;
      pattern_flag_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= gpt_pkg::MODE_TOP;
      class_set     <= '0;
      pending_first <= '0;
      class_negated <= 1'b0;
      valid_flag    <= 1'b1;
      pattern_flag  <= 1'b0;
    end else if (accept) begin
      mode          <= mode_next;
      class_set     <= class_set_next;
      pending_first <= pending_first_next;
      class_negated <= class_negated_next;
      valid_flag    <= valid_flag_next;
      pattern_flag  <= pattern_flag_next;
    end
  end

endmodule

// ===== rtl/gpt_queue.sv =====
// short queue of parsed atoms between the front and back ends
// depends on gpt_pkg
module gpt_queue #(
  parameter int DEPTH = gpt_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  gpt_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output gpt_pkg::entry_t head_entry
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  gpt_pkg::entry_t entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/gpt_back.sv =====
// back end: expands queued atoms into results, four set words for a class
// depends on gpt_pkg
module gpt_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  gpt_pkg::entry_t  head_entry,
  output logic             pop,
  output logic             atom_valid,
  input  logic             atom_stall,
  output gpt_pkg::out_req_t atom_req
);

  logic              load;
  logic              is_class;
  logic              last_word;
  logic [1:0]        word_cnt;
  gpt_pkg::out_req_t result;

  assign load      = !atom_valid || !atom_stall;
  assign is_class  = (head_entry.kind == gpt_pkg::KIND_CLASS) ||
                     (head_entry.kind == gpt_pkg::KIND_NEG_CLASS);
  assign last_word = !is_class || (word_cnt == 2'd3);
  assign pop       = load && head_valid && last_word;

  always_comb begin
    result                 = '0;
    result.atom_kind       = head_entry.kind;
    result.literal_byte    = head_entry.lit;
    result.set_word        = is_class ? head_entry.set_words[word_cnt] : '0;
    result.word_index      = is_class ? word_cnt : 2'd0;
    result.last_of_run     = last_word;
    result.name_done       = head_entry.done && last_word;
    result.name_valid      = head_entry.name_valid;
    result.name_is_pattern = head_entry.name_pattern;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      atom_valid <= 1'b0;
      word_cnt   <= '0;
    end else if (load) begin
      atom_valid <= head_valid;
      if (head_valid) begin
        word_cnt <= last_word ? 2'd0 : word_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      atom_req <= result;
    end
  end

endmodule

// ===== tb/glob_pattern_tokenizer_tb.sv =====
// self-checking testbench for glob_pattern_tokenizer: directed names, then random phases
// with varied idling and a long output hold-off; depends on gpt_pkg and the tokenizer rtl
`timescale 1ns / 1ps

module glob_pattern_tokenizer_tb;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              byte_valid = 1'b0;
  logic              byte_stall;
  gpt_pkg::in_req_t  byte_req = '0;
  logic              atom_valid;
  logic              atom_stall = 1'b0;
  gpt_pkg::out_req_t atom_req;

  glob_pattern_tokenizer i_dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_req   (byte_req),
    .atom_valid (atom_valid),
    .atom_stall (atom_stall),
    .atom_req   (atom_req)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  gpt_pkg::in_req_t  byte_plan[$];
  logic [7:0]        name_bytes[$];
  gpt_pkg::out_req_t atom_expect[$];
  gpt_pkg::out_req_t atom_run[$];
  gpt_pkg::out_req_t atom_want;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_ticket = 0;
  int hold_seen;
  int hold_left;
  int planned_bytes = 0;
  int bytes_taken = 0;
  int atoms_checked = 0;
  int names_done = 0;
  int class_words = 0;
  int input_held = 0;
  int fail_count = 0;

  // tokenizer state as predicted
  gpt_pkg::mode_t tok_mode = gpt_pkg::MODE_TOP;
  logic [255:0]   cls_bits = '0;
  logic [7:0]     tok_first = '0;
  logic           tok_neg = 1'b0;
  logic           tok_ok = 1'b1;
  logic           tok_pat = 1'b0;

  task automatic add_byte(input logic [7:0] b);
    name_bytes = {name_bytes, b};
  endtask

  task automatic emit_atom(input gpt_pkg::atom_kind_t kind, input logic [7:0] lit,
                           input logic [63:0] word, input logic [1:0] idx);
    gpt_pkg::out_req_t a;
    a = '0;
    a.atom_kind = kind;
    a.literal_byte = lit;
    a.set_word = word;
    a.word_index = idx;
    atom_run = {atom_run, a};
  endtask

  task automatic close_class();
    for (int w = 0; w < 4; w++)
      emit_atom(tok_neg ? gpt_pkg::KIND_NEG_CLASS : gpt_pkg::KIND_CLASS, '0,
                cls_bits[w*64 +: 64], w[1:0]);
    cls_bits = '0;
    tok_neg = 1'b0;
    tok_mode = gpt_pkg::MODE_TOP;
  endtask

  task automatic member_at(input logic [7:0] c);
    if (c == gpt_pkg::CH_CLOSE && cls_bits != '0) begin
      close_class();
    end else if (c == gpt_pkg::CH_BSLASH) begin
      tok_mode = gpt_pkg::MODE_CLS_ESC;
    end else begin
      tok_first = c;
      tok_mode = gpt_pkg::MODE_CLS_AFTER;
    end
  endtask

  task automatic add_span(input int lo, input int hi);
    for (int v = lo; v <= hi; v++)
      cls_bits[v] = 1'b1;
  endtask

  task automatic range_to(input logic [7:0] c);
    if (tok_first > c) begin
      tok_ok = 1'b0;
      cls_bits = '0;
      tok_mode = gpt_pkg::MODE_TOP;
    end else begin
      add_span(int'(tok_first), int'(c));
      tok_mode = gpt_pkg::MODE_CLS_MEMBER;
    end
  endtask

  task automatic predict_byte(input gpt_pkg::in_req_t rq);
    logic [7:0] c;
    int n;
    c = rq.char_in;
    atom_run.delete();
    if (tok_ok) begin
      case (tok_mode)
        gpt_pkg::MODE_TOP: begin
          if (c == gpt_pkg::CH_QUESTION) begin
            tok_pat = 1'b1;
            emit_atom(gpt_pkg::KIND_WILDCARD, '0, '0, '0);
          end else if (c == gpt_pkg::CH_STAR) begin
            tok_pat = 1'b1;
            emit_atom(gpt_pkg::KIND_GLOB, '0, '0, '0);
          end else if (c == gpt_pkg::CH_OPEN) begin
            tok_pat = 1'b1;
            cls_bits = '0;
            tok_neg = 1'b0;
            tok_mode = gpt_pkg::MODE_CLS_START;
          end else if (c == gpt_pkg::CH_BSLASH) begin
            tok_mode = gpt_pkg::MODE_TOP_ESC;
          end else begin
            emit_atom(gpt_pkg::KIND_LITERAL, c, '0, '0);
          end
        end
        gpt_pkg::MODE_TOP_ESC: begin
          emit_atom(gpt_pkg::KIND_LITERAL, c, '0, '0);
          tok_mode = gpt_pkg::MODE_TOP;
        end
        gpt_pkg::MODE_CLS_START: begin
          if (c == gpt_pkg::CH_BANG) begin
            tok_neg = 1'b1;
            tok_mode = gpt_pkg::MODE_CLS_MEMBER;
          end else begin
            member_at(c);
          end
        end
        gpt_pkg::MODE_CLS_MEMBER: member_at(c);
        gpt_pkg::MODE_CLS_ESC: begin
          tok_first = c;
          tok_mode = gpt_pkg::MODE_CLS_AFTER;
        end
        gpt_pkg::MODE_CLS_AFTER: begin
          if (c == gpt_pkg::CH_DASH) begin
            tok_mode = gpt_pkg::MODE_RNG_NEED;
          end else begin
            add_span(int'(tok_first), int'(tok_first));
            member_at(c);
          end
        end
        gpt_pkg::MODE_RNG_NEED: begin
          if (c == gpt_pkg::CH_BSLASH) tok_mode = gpt_pkg::MODE_RNG_ESC;
          else range_to(c);
        end
        default: range_to(c);
      endcase
    end
    if (rq.end_of_name) begin
      if (tok_ok && tok_mode != gpt_pkg::MODE_TOP) tok_ok = 1'b0;
      if (atom_run.size() == 0) emit_atom(gpt_pkg::KIND_STATUS, '0, '0, '0);
    end
    n = atom_run.size();
    for (int k = 0; k < n; k++) begin
      atom_run[k].last_of_run = (k == n - 1);
      atom_run[k].name_done = rq.end_of_name && (k == n - 1);
      atom_run[k].name_valid = tok_ok;
      atom_run[k].name_is_pattern = tok_pat;
      atom_expect = {atom_expect, atom_run[k]};
    end
    if (rq.end_of_name) begin
      tok_mode = gpt_pkg::MODE_TOP;
      cls_bits = '0;
      tok_first = '0;
      tok_neg = 1'b0;
      tok_ok = 1'b1;
      tok_pat = 1'b0;
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      if (byte_valid && !byte_stall) begin
        predict_byte(byte_req);
        bytes_taken++;
      end
      if (byte_valid && byte_stall) input_held++;
      if (!byte_valid || !byte_stall) begin
        if (byte_plan.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          byte_valid <= 1'b1;
          byte_req <= byte_plan.pop_front();
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      atom_stall <= 1'b0;
      hold_seen <= 0;
      hold_left <= 0;
    end else if (hold_ticket != hold_seen) begin
      hold_seen <= hold_ticket;
      hold_left <= 300;
      atom_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      atom_stall <= 1'b1;
    end else begin
      atom_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic check_field(input string fname, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && atom_valid && !atom_stall) begin
      if (atom_expect.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected request, expected none, actual %h", $time, atom_req);
      end else begin
        atom_want = atom_expect.pop_front();
        check_field("atom_kind", 64'(atom_want.atom_kind), 64'(atom_req.atom_kind));
        check_field("literal_byte", 64'(atom_want.literal_byte),
                    64'(atom_req.literal_byte));
        check_field("set_word", atom_want.set_word, atom_req.set_word);
        check_field("word_index", 64'(atom_want.word_index), 64'(atom_req.word_index));
        check_field("last_of_run", 64'(atom_want.last_of_run), 64'(atom_req.last_of_run));
        check_field("name_done", 64'(atom_want.name_done), 64'(atom_req.name_done));
        check_field("name_valid", 64'(atom_want.name_valid), 64'(atom_req.name_valid));
        check_field("name_is_pattern", 64'(atom_want.name_is_pattern),
                    64'(atom_req.name_is_pattern));
      end
      atoms_checked++;
      if (atom_req.name_done) names_done++;
      if (atom_req.atom_kind == gpt_pkg::KIND_CLASS ||
          atom_req.atom_kind == gpt_pkg::KIND_NEG_CLASS)
        class_words++;
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(13))
      0: return gpt_pkg::CH_QUESTION;
      1: return gpt_pkg::CH_STAR;
      2: return gpt_pkg::CH_OPEN;
      3: return gpt_pkg::CH_BANG;
      4: return gpt_pkg::CH_DASH;
      5: return gpt_pkg::CH_BSLASH;
      6: return gpt_pkg::CH_CLOSE;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic queue_name();
    gpt_pkg::in_req_t r;
    for (int k = 0; k < name_bytes.size(); k++) begin
      r.char_in = name_bytes[k];
      r.end_of_name = (k == name_bytes.size() - 1);
      byte_plan = {byte_plan, r};
    end
    planned_bytes += name_bytes.size();
    name_bytes.delete();
  endtask

  task automatic add_class();
    logic [7:0] s;
    logic [7:0] e;
    int lim;
    int nm;
    add_byte(gpt_pkg::CH_OPEN);
    if ($urandom_range(1)) add_byte(gpt_pkg::CH_BANG);
    nm = $urandom_range(4, 1);
    for (int i = 0; i < nm; i++) begin
      s = pick_byte();
      if (s == gpt_pkg::CH_BSLASH || s == gpt_pkg::CH_DASH ||
          (s == gpt_pkg::CH_CLOSE && i > 0) || (s == gpt_pkg::CH_BANG && i == 0))
        add_byte(gpt_pkg::CH_BSLASH);
      add_byte(s);
      if ($urandom_range(1)) begin
        add_byte(gpt_pkg::CH_DASH);
        lim = (int'(s) + 24 > 255 || $urandom_range(3) == 0) ? 255 : int'(s) + 24;
        e = 8'($urandom_range(lim, int'(s)));
        if (e == gpt_pkg::CH_BSLASH) add_byte(gpt_pkg::CH_BSLASH);
        add_byte(e);
      end
    end
    add_byte(gpt_pkg::CH_CLOSE);
  endtask

  task automatic add_atom();
    logic [7:0] c;
    case ($urandom_range(7))
      0, 1, 7: begin
        c = pick_byte();
        if (c == gpt_pkg::CH_QUESTION || c == gpt_pkg::CH_STAR ||
            c == gpt_pkg::CH_OPEN || c == gpt_pkg::CH_BSLASH)
          add_byte(gpt_pkg::CH_BSLASH);
        add_byte(c);
      end
      2: add_byte(gpt_pkg::CH_QUESTION);
      3: add_byte(gpt_pkg::CH_STAR);
      4: begin
        add_byte(gpt_pkg::CH_BSLASH);
        add_byte(8'($urandom_range(255)));
      end
      default: add_class();
    endcase
  endtask

  task automatic add_name();
    int r;
    int hi;
    int cut;
    r = $urandom_range(99);
    if (r < 80) begin
      repeat ($urandom_range(6, 1)) add_atom();
    end else if (r < 88) begin
      repeat ($urandom_range(4, 1)) add_atom();
      cut = $urandom_range(name_bytes.size(), 1);
      while (name_bytes.size() > cut) void'(name_bytes.pop_back());
    end else if (r < 94) begin
      // reversed range, then trailing bytes that are ignored
      repeat ($urandom_range(2)) add_atom();
      hi = $urandom_range(255, 1);
      add_byte(gpt_pkg::CH_OPEN);
      add_byte(gpt_pkg::CH_BSLASH);
      add_byte(8'(hi));
      add_byte(gpt_pkg::CH_DASH);
      add_byte(gpt_pkg::CH_BSLASH);
      add_byte(8'($urandom_range(hi - 1, 0)));
      add_byte(gpt_pkg::CH_CLOSE);
      repeat ($urandom_range(2)) add_atom();
    end else begin
      repeat ($urandom_range(8, 1)) add_byte(pick_byte());
    end
    queue_name();
  endtask

  task automatic drain_all();
    while (byte_plan.size() > 0 || byte_valid || atom_expect.size() > 0)
      @(negedge clk);
  endtask

  task automatic run_phase(input int idle, input int stl, input int nbytes);
    int start;
    @(negedge clk);
    send_idle_pct = idle;
    stall_pct = stl;
    start = planned_bytes;
    while (planned_bytes - start < nbytes) add_name();
    drain_all();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    name_bytes = {8'h00};
    queue_name();
    name_bytes = {8'hFF, gpt_pkg::CH_QUESTION, gpt_pkg::CH_STAR};
    queue_name();
    name_bytes = {gpt_pkg::CH_BSLASH, gpt_pkg::CH_OPEN};
    queue_name();
    name_bytes = {gpt_pkg::CH_OPEN, gpt_pkg::CH_CLOSE, "a", gpt_pkg::CH_DASH, "c",
                  gpt_pkg::CH_CLOSE};
    queue_name();
    name_bytes = {gpt_pkg::CH_OPEN, gpt_pkg::CH_BANG, gpt_pkg::CH_BSLASH, gpt_pkg::CH_CLOSE,
                  gpt_pkg::CH_DASH, 8'hFF, gpt_pkg::CH_CLOSE};
    queue_name();
    name_bytes = {gpt_pkg::CH_OPEN, "z", gpt_pkg::CH_DASH, "a", "q"};
    queue_name();
    name_bytes = {gpt_pkg::CH_BSLASH};
    queue_name();
    drain_all();

    run_phase(0, 0, 80);
    run_phase(59, 0, 70);
    run_phase(0, 59, 70);
    run_phase(16, 16, 70);

    // output held off while dense class names keep arriving
    @(negedge clk);
    send_idle_pct = 0;
    stall_pct = 0;
    hold_ticket = hold_ticket + 1;
    repeat (20) begin
      name_bytes = {gpt_pkg::CH_OPEN, 8'($urandom_range(8'h7A, 8'h61)), gpt_pkg::CH_CLOSE};
      queue_name();
    end
    repeat (5) add_name();
    drain_all();

    repeat (20) @(negedge clk);
    $display("%0d requests in, %0d results checked over %0d names, %0d class words",
             bytes_taken, atoms_checked, names_done, class_words);
    $display("input held by the block for %0d cycles", input_held);
    if (fail_count == 0) begin
      $display("glob_pattern_tokenizer verification clean");
    end else begin
      $display("glob_pattern_tokenizer verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("glob_pattern_tokenizer verification failed");
    $finish;
  end

endmodule
